[rtl/core/class_pattern_line_matcher_macros.svh]
// ----------------------------------------------------------------------------
// class_pattern_line_matcher_macros
// assertion macros for the matcher rtl
// ----------------------------------------------------------------------------
`ifndef CLASS_PATTERN_LINE_MATCHER_MACROS_SVH
`define CLASS_PATTERN_LINE_MATCHER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cplm_pkg.sv]
// ----------------------------------------------------------------------------
// cplm_pkg
// types and codes shared by the character-class line matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cplm_pkg;

  // field widths, table depth and cell limit
  localparam int CHAR_W  = 8;
  localparam int MASK_W  = 32;
  localparam int IDX_W   = 12;
  localparam int STAT_W  = 2;
  localparam int QLEN_W  = 6;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 6;
  localparam int TBL_DEPTH = 256;
  localparam int CELL_MAX  = 32;

  // word opcodes
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TEXT = 1'b1;

  // register indexes
  localparam logic CFG_QLEN = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // match modes
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUFFIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBSTR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUBSEQ = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MATCH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LONG  = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic upd;  // byte inside line limit: shift the chain
    logic go;   // a text word leaves the match stage
    logic clr;  // that word ends its line
  } cell_ctl_t;

endpackage

[rtl/core/class_pattern_line_matcher.sv]
// ----------------------------------------------------------------------------
// class_pattern_line_matcher
// character-class query matcher over streamed text lines (shift-and chain)
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | opcode, char_value, mask, line_end
//   out     | output    | out_valid/out_stall| status, start_index, end_index
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// one word per cycle while in_stall is low; the class table read of a byte is
// registered, and when the byte leaves the match stage the chain of cells
// updates while a line result is loaded into the output register (out_valid)
// reset clears the class table valid bits at once, so there is no clearing pass
// in_stall rises only while a line-end byte waits behind an unaccepted result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "class_pattern_line_matcher_macros.svh"

module class_pattern_line_matcher #(
  parameter int MAX_QUERY = 32,
  parameter int MAX_LINE  = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // text and load words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [cplm_pkg::CHAR_W-1:0] in_char_value,
  input  logic [cplm_pkg::MASK_W-1:0] in_position_mask,
  input  logic                        in_line_end,
  // line results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cplm_pkg::STAT_W-1:0] out_status,
  output logic [cplm_pkg::IDX_W-1:0]  out_start_index,
  output logic [cplm_pkg::IDX_W-1:0]  out_end_index,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [cplm_pkg::CFG_W-1:0]  cfg_data
);

  localparam int NCELL = (MAX_QUERY < cplm_pkg::CELL_MAX) ? MAX_QUERY : cplm_pkg::CELL_MAX;
  localparam int QW    = $clog2(NCELL + 1);
  localparam int PW    = $clog2(MAX_LINE + 1);
  localparam int RW    = PW + cplm_pkg::IDX_W;

  // configuration registers
  logic [cplm_pkg::QLEN_W-1:0] qlen_r;
  logic [cplm_pkg::MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= cplm_pkg::QLEN_W'(1);
      mode_r <= cplm_pkg::MODE_SUBSTR;
    end else if (cfg_we) begin
      case (cfg_index)
        cplm_pkg::CFG_QLEN: qlen_r <= cfg_data;
        cplm_pkg::CFG_MODE: mode_r <= cfg_data[cplm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective query length: zero taken as one, clamped to the cell count
  logic [QW-1:0] q_eff;
  always_comb begin
    if (qlen_r == '0) begin
      q_eff = QW'(1);
    end else if (qlen_r > cplm_pkg::QLEN_W'(NCELL)) begin
      q_eff = QW'(NCELL);
    end else begin
      q_eff = QW'(qlen_r);
    end
  end

  // input acceptance and match-stage hand-off
  logic in_acc;
  logic s1_v_r, s1_v_nxt;
  logic s1_eol_r;
  logic s1_go;
  logic s1_block;
  logic emit;

  assign s1_block = s1_v_r & s1_eol_r & out_valid & out_stall;
  assign in_stall = s1_block;
  assign in_acc   = in_valid & ~in_stall;
  assign s1_go    = s1_v_r & ~s1_block;
  assign emit     = s1_go & s1_eol_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = (in_opcode == cplm_pkg::OPC_TEXT);
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_eol_r <= in_line_end;
    end
  end

  // class mask table
  logic [cplm_pkg::MASK_W-1:0] tbl_rd;

  cplm_class_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc & (in_opcode == cplm_pkg::OPC_LOAD)),
    .wr_addr (in_char_value),
    .wr_data (in_position_mask),
    .rd_en   (in_acc & (in_opcode == cplm_pkg::OPC_TEXT)),
    .rd_addr (in_char_value),
    .rd_data (tbl_rd)
  );

  // line state
  logic [PW-1:0]              pos_r;
  logic                       long_r;
  logic                       prefix_r;
  logic [QW-1:0]              sub_r;
  logic                       found_r;
  logic [cplm_pkg::IDX_W-1:0] mstart_r;
  logic [cplm_pkg::IDX_W-1:0] mend_r;

  logic                       ovl;
  cplm_pkg::cell_ctl_t        ctl;
  logic [NCELL-1:0]           low;
  logic [NCELL-1:0]           m;
  logic [NCELL-1:0]           act_q;
  logic [NCELL-1:0]           act_new;
  logic [NCELL-1:0]           kill;

  assign ovl     = (pos_r >= PW'(MAX_LINE));
  assign ctl.go  = s1_go;
  assign ctl.upd = s1_go & ~ovl;
  assign ctl.clr = s1_eol_r;
  assign m       = tbl_rd[NCELL-1:0] & low;

  // chain of query-position cells
  genvar j;
  generate
    for (j = 0; j < NCELL; j++) begin : g_cell
      logic left;
      if (j == 0) begin : g_head
        assign left = 1'b1;
      end else begin : g_link
        assign left = act_q[j-1];
      end
      assign low[j] = (32'(q_eff) > j);

      cplm_cell #(
        .IDX (j),
        .PW  (PW)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .left_in  (left),
        .mask_bit (m[j]),
        .in_query (low[j]),
        .line_pos (pos_r),
        .act_q    (act_q[j]),
        .act_new  (act_new[j]),
        .kill     (kill[j])
      );
    end
  endgenerate

  // per-byte updates of position, prefix, substring and subsequence tracking
  logic [NCELL:0]             act_ext;
  logic [NCELL:0]             m_ext;
  logic                       top_hit;
  logic [PW-1:0]              pos_new;
  logic                       long_new;
  logic                       prefix_new;
  logic [QW-1:0]              sub_new;
  logic                       found_new;
  logic [cplm_pkg::IDX_W-1:0] mstart_new;
  logic [cplm_pkg::IDX_W-1:0] mend_new;
  logic [RW-1:0]              p_w;
  logic [RW-1:0]              q_w;
  logic [RW-1:0]              len_w;
  logic [RW-1:0]              sub_start_w;
  logic [RW-1:0]              suf_start_w;
  logic [RW-1:0]              suf_end_w;
  logic [RW-1:0]              pre_end_w;

  assign act_ext     = {1'b0, act_new};
  assign m_ext       = {1'b0, m};
  assign top_hit     = act_ext[q_eff - QW'(1)];
  assign p_w         = RW'(pos_r);
  assign q_w         = RW'(q_eff);
  assign len_w       = RW'(pos_new);
  assign sub_start_w = p_w + RW'(1) - q_w;
  assign suf_start_w = len_w - q_w;
  assign suf_end_w   = len_w - RW'(1);
  assign pre_end_w   = q_w - RW'(1);

  always_comb begin
    pos_new    = ctl.upd ? (pos_r + PW'(1)) : pos_r;
    long_new   = long_r | (s1_go & ovl);
    prefix_new = prefix_r & ~(ctl.upd & (|kill));
    sub_new    = sub_r;
    found_new  = found_r;
    mstart_new = mstart_r;
    mend_new   = mend_r;
    if (ctl.upd) begin
      if ((mode_r == cplm_pkg::MODE_SUBSTR) && !found_r && top_hit) begin
        found_new  = 1'b1;
        mstart_new = sub_start_w[cplm_pkg::IDX_W-1:0];
        mend_new   = p_w[cplm_pkg::IDX_W-1:0];
      end
      if ((mode_r == cplm_pkg::MODE_SUBSEQ) && (sub_r < q_eff) && m_ext[sub_r]) begin
        if (sub_r == '0) begin
          mstart_new = p_w[cplm_pkg::IDX_W-1:0];
        end
        sub_new = sub_r + QW'(1);
        if ((sub_r + QW'(1)) == q_eff) begin
          mend_new = p_w[cplm_pkg::IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      long_r   <= 1'b0;
      prefix_r <= 1'b1;
      sub_r    <= '0;
      found_r  <= 1'b0;
      mstart_r <= '0;
      mend_r   <= '0;
    end else if (s1_go) begin
      if (s1_eol_r) begin
        pos_r    <= '0;
        long_r   <= 1'b0;
        prefix_r <= 1'b1;
        sub_r    <= '0;
        found_r  <= 1'b0;
        mstart_r <= '0;
        mend_r   <= '0;
      end else begin
        pos_r    <= pos_new;
        long_r   <= long_new;
        prefix_r <= prefix_new;
        sub_r    <= sub_new;
        found_r  <= found_new;
        mstart_r <= mstart_new;
        mend_r   <= mend_new;
      end
    end
  end

  // line result from the state after the line-end byte
  logic [cplm_pkg::STAT_W-1:0] res_stat;
  logic [cplm_pkg::IDX_W-1:0]  res_start;
  logic [cplm_pkg::IDX_W-1:0]  res_end;

  always_comb begin
    res_stat  = cplm_pkg::STAT_NONE;
    res_start = '0;
    res_end   = '0;
    if (long_new) begin
      res_stat = cplm_pkg::STAT_LONG;
    end else begin
      case (mode_r)
        cplm_pkg::MODE_PREFIX: begin
          if ((len_w >= q_w) && prefix_new) begin
            res_stat = cplm_pkg::STAT_MATCH;
            res_end  = pre_end_w[cplm_pkg::IDX_W-1:0];
          end
        end
        cplm_pkg::MODE_SUFFIX: begin
          if ((len_w >= q_w) && top_hit) begin
            res_stat  = cplm_pkg::STAT_MATCH;
            res_start = suf_start_w[cplm_pkg::IDX_W-1:0];
            res_end   = suf_end_w[cplm_pkg::IDX_W-1:0];
          end
        end
        cplm_pkg::MODE_SUBSTR: begin
          if (found_new) begin
            res_stat  = cplm_pkg::STAT_MATCH;
            res_start = mstart_new;
            res_end   = mend_new;
          end
        end
        default: begin
          if (sub_new >= q_eff) begin
            res_stat  = cplm_pkg::STAT_MATCH;
            res_start = mstart_new;
            res_end   = mend_new;
          end
        end
      endcase
    end
  end

  // output register
  logic out_v_r, out_v_nxt;
  logic [cplm_pkg::STAT_W-1:0] out_stat_r;
  logic [cplm_pkg::IDX_W-1:0]  out_start_r;
  logic [cplm_pkg::IDX_W-1:0]  out_end_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_stat_r  <= res_stat;
      out_start_r <= res_start;
      out_end_r   <= res_end;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_stat_r;
  assign out_start_index = out_start_r;
  assign out_end_index   = out_end_r;

  // checks
  `CPLM_ASSERT_NOW(a_nomatch_zero, clk, rst_n, out_valid && (out_status != cplm_pkg::STAT_MATCH), (out_start_index == '0) && (out_end_index == '0), "non-match result with nonzero indices")
  `CPLM_ASSERT_NEXT(a_line_restart, clk, rst_n, emit, (pos_r == '0) && (act_q == '0) && prefix_r && !long_r, "line state not cleared after line end")
  `CPLM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall && s1_v_r, "input stalled without a blocked result")
  `CPLM_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_r <= PW'(MAX_LINE), "line position beyond line limit")

endmodule

[rtl/core/cplm_class_table.sv]
// ----------------------------------------------------------------------------
// cplm_class_table
// 256-entry class mask store with per-entry valid bits, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cplm_class_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [cplm_pkg::CHAR_W-1:0] wr_addr,
  input  logic [cplm_pkg::MASK_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [cplm_pkg::CHAR_W-1:0] rd_addr,
  output logic [cplm_pkg::MASK_W-1:0] rd_data
);

  logic [cplm_pkg::MASK_W-1:0]    mem [cplm_pkg::TBL_DEPTH];
  logic [cplm_pkg::TBL_DEPTH-1:0] vld_r;
  logic [cplm_pkg::MASK_W-1:0]    rd_data_r;
  logic                           rd_vld_r;

  // storage array, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[rtl/core/cplm_cell.sv]
// ----------------------------------------------------------------------------
// cplm_cell
// one query position: shift-and bit and prefix check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cplm_cell #(
  parameter int IDX = 0,
  parameter int PW  = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cplm_pkg::cell_ctl_t ctl,
  input  logic                left_in,   // registered bit of the cell below
  input  logic                mask_bit,  // class bit of this position
  input  logic                in_query,  // position below query length
  input  logic [PW-1:0]       line_pos,
  output logic                act_q,     // registered bit, to the cell above
  output logic                act_new,   // bit after this byte
  output logic                kill
);

  logic act_r;
  logic act_nxt;

  // shift-and step: alive if the shorter prefix was alive and the byte fits
  assign act_new = ctl.upd ? (left_in & mask_bit) : act_r;

  // prefix broken when the byte at this index misses this class
  assign kill = (32'(line_pos) == IDX) & in_query & ~mask_bit;

  always_comb begin
    act_nxt = act_r;
    if (ctl.go) begin
      act_nxt = ctl.clr ? 1'b0 : act_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  assign act_q = act_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the character-class line matcher
//
// a stimulus process queues class loads and text lines; a clocked driver
// sends them in random bursts while the receiver stalls on its own pattern.
// a behavioural copy of the matcher runs on every accepted word and its line
// reports are compared in order with the output channel. query length and
// match mode are rewritten between phases once the pipeline has drained,
// sometimes with a line left open across the change
// ---------------------------------------------------------------------------
module tb_top;
  import cplm_pkg::*;

  localparam int MAX_QUERY    = 32;
  localparam int MAX_LINE     = 4096;
  localparam int QUERY_CAP    = (MAX_QUERY < 32) ? MAX_QUERY : 32;
  localparam int RANDOM_WORDS = 1550;
  localparam int PHASES       = 16;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] char_value;
    logic [MASK_W-1:0] position_mask;
    logic              line_end;
  } matcher_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  start_index;
    logic [IDX_W-1:0]  end_index;
  } line_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OPC_LOAD;
  logic [CHAR_W-1:0] in_char_value = '0;
  logic [MASK_W-1:0] in_position_mask = '0;
  logic              in_line_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_start_index;
  logic [IDX_W-1:0]  out_end_index;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_QLEN;
  logic [CFG_W-1:0]  cfg_data = '0;

  class_pattern_line_matcher #(
    .MAX_QUERY(MAX_QUERY),
    .MAX_LINE (MAX_LINE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_char_value   (in_char_value),
    .in_position_mask(in_position_mask),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_start_index (out_start_index),
    .out_end_index   (out_end_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  matcher_word_t words_to_send[$];
  line_report_t  reports_due[$];

  // run bookkeeping
  int unsigned mismatches = 0;
  int unsigned reports_checked = 0;
  int unsigned words_taken = 0;
  int unsigned loads_taken = 0;
  int unsigned cfg_writes = 0;
  int unsigned drain_pauses = 0;
  int unsigned n_match = 0;
  int unsigned n_none = 0;
  int unsigned n_long = 0;

  // ---------------------------------------------------------------------
  // matcher model: class table, shift-and bits and line trackers
  // ---------------------------------------------------------------------
  logic [MASK_W-1:0] class_tbl [TBL_DEPTH];
  logic [MASK_W-1:0] shift_bits;
  logic [QLEN_W-1:0] qlen_reg;
  logic [MODE_W-1:0] mode_reg;
  int unsigned       line_pos;
  int unsigned       subseq_idx;
  int unsigned       hit_start;
  int unsigned       hit_end;
  logic              prefix_ok;
  logic              hit_found;
  logic              over_limit;

  task automatic restart_line();
    shift_bits = '0;
    line_pos   = 0;
    prefix_ok  = 1'b1;
    subseq_idx = 0;
    hit_found  = 1'b0;
    hit_start  = 0;
    hit_end    = 0;
    over_limit = 1'b0;
  endtask

  task automatic advance_matcher(input matcher_word_t w);
    int unsigned       q;
    int unsigned       p;
    logic [MASK_W-1:0] low;
    logic [MASK_W-1:0] top;
    logic [MASK_W-1:0] m;
    line_report_t      rep;
    q = (qlen_reg == 0) ? 1 : int'(qlen_reg);
    if (q > QUERY_CAP) q = QUERY_CAP;
    low = {MASK_W{1'b1}} >> (MASK_W - q);
    top = low ^ (low >> 1);
    if (w.opcode == OPC_LOAD) begin
      // class load: line_end plays no part
      class_tbl[w.char_value] = w.position_mask;
      loads_taken++;
    end else begin
      p = line_pos;
      if (p >= MAX_LINE) begin
        over_limit = 1'b1;
      end else begin
        m = class_tbl[w.char_value] & low;
        shift_bits = ((shift_bits << 1) | 1) & m;
        if (p < q && !m[p]) prefix_ok = 1'b0;
        if (mode_reg == MODE_SUBSTR && !hit_found && (shift_bits & top) != 0) begin
          hit_found = 1'b1;
          hit_start = p + 1 - q;
          hit_end   = p;
        end
        if (mode_reg == MODE_SUBSEQ && subseq_idx < q && m[subseq_idx]) begin
          if (subseq_idx == 0) hit_start = p;
          subseq_idx++;
          if (subseq_idx == q) hit_end = p;
        end
        line_pos = p + 1;
      end
      // line end: one report under the mode in force now
      if (w.line_end) begin
        rep = '{status: STAT_NONE, start_index: '0, end_index: '0};
        if (over_limit) begin
          rep.status = STAT_LONG;
        end else begin
          case (mode_reg)
            MODE_PREFIX: if (line_pos >= q && prefix_ok) begin
              rep.status    = STAT_MATCH;
              rep.end_index = IDX_W'(q - 1);
            end
            MODE_SUFFIX: if (line_pos >= q && (shift_bits & top) != 0) begin
              rep.status      = STAT_MATCH;
              rep.start_index = IDX_W'(line_pos - q);
              rep.end_index   = IDX_W'(line_pos - 1);
            end
            MODE_SUBSTR: if (hit_found) begin
              rep.status      = STAT_MATCH;
              rep.start_index = IDX_W'(hit_start);
              rep.end_index   = IDX_W'(hit_end);
            end
            MODE_SUBSEQ: if (subseq_idx >= q) begin
              rep.status      = STAT_MATCH;
              rep.start_index = IDX_W'(hit_start);
              rep.end_index   = IDX_W'(hit_end);
            end
          endcase
        end
        case (rep.status)
          STAT_MATCH: n_match++;
          STAT_LONG:  n_long++;
          default:    n_none++;
        endcase
        reports_due.push_back(rep);
        restart_line();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // monitor: check reports, track register writes, predict accepted words
  // ---------------------------------------------------------------------
  logic in_fire = 1'b0;

  always @(posedge clk) begin
    line_report_t  want;
    matcher_word_t w;
    if (!rst_n) begin
      foreach (class_tbl[i]) class_tbl[i] = '0;
      qlen_reg = QLEN_W'(1);
      mode_reg = MODE_SUBSTR;
      restart_line();
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected line report: status %0d start %0d end %0d",
                     out_status, out_start_index, out_end_index);
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          if (out_status !== want.status || out_start_index !== want.start_index ||
              out_end_index !== want.end_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("line report %0d mismatch: expected status %0d start %0d end %0d,",
                       reports_checked, want.status, want.start_index, want.end_index);
              $display("  got status %0d start %0d end %0d",
                       out_status, out_start_index, out_end_index);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_QLEN) qlen_reg = cfg_data[QLEN_W-1:0];
        else mode_reg = cfg_data[MODE_W-1:0];
      end
      if (in_valid && !in_stall) begin
        w = '{opcode: in_opcode, char_value: in_char_value,
              position_mask: in_position_mask, line_end: in_line_end};
        advance_matcher(w);
        words_taken++;
      end
      in_fire <= in_valid && !in_stall;
    end
  end

  // ---------------------------------------------------------------------
  // word driver: random bursts and gaps, now and then a full drain
  // ---------------------------------------------------------------------
  int   burst_left = 0;
  int   gap_left = 0;
  logic drain_hold = 1'b0;

  always @(negedge clk) begin
    matcher_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (drain_hold) begin
        in_valid <= 1'b0;
        if (reports_due.size() == 0) drain_hold = 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (words_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        w = words_to_send.pop_front();
        in_valid         <= 1'b1;
        in_opcode        <= w.opcode;
        in_char_value    <= w.char_value;
        in_position_mask <= w.position_mask;
        in_line_end      <= w.line_end;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 7))
            0: begin
              burst_left = $urandom_range(64, 256);
              gap_left   = 0;
            end
            1: begin
              burst_left = 1;
              gap_left   = $urandom_range(1, 3);
            end
            default: begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(0, 8);
            end
          endcase
          if ((drain_pauses == 0 && reports_due.size() != 0) ||
              $urandom_range(0, 39) == 0) begin
            drain_hold = 1'b1;
            drain_pauses++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stall style is redrawn from four styles whenever its run ends
  // ---------------------------------------------------------------------
  int          stall_style = 0;
  int          style_left = 0;
  int unsigned rx_cycle = 0;

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(32, 256);
    end else begin
      style_left--;
    end
    rx_cycle++;
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (rx_cycle % 7) < 4;
    endcase
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  logic [MASK_W-1:0] plan_tbl [TBL_DEPTH];  // table as the stimulus has written it
  logic [CHAR_W-1:0] alphabet[$];
  logic [CHAR_W-1:0] query_bytes [MAX_QUERY];
  logic [CHAR_W-1:0] line_buf[$];
  int unsigned       words_queued = 0;

  task automatic queue_load(input logic [CHAR_W-1:0] c, input logic [MASK_W-1:0] mask,
                            input logic le);
    matcher_word_t w;
    w = '{opcode: OPC_LOAD, char_value: c, position_mask: mask, line_end: le};
    words_to_send.push_back(w);
    plan_tbl[c] = mask;
    words_queued++;
  endtask

  task automatic queue_text(input logic [CHAR_W-1:0] c, input logic le);
    matcher_word_t w;
    w = '{opcode: OPC_TEXT, char_value: c, position_mask: $urandom(), line_end: le};
    words_to_send.push_back(w);
    words_queued++;
  endtask

  function automatic logic [CHAR_W-1:0] filler();
    if ($urandom_range(0, 1) == 1) return alphabet[$urandom_range(0, alphabet.size() - 1)];
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // a byte that query position j does not accept, if one turns up quickly
  function automatic logic [CHAR_W-1:0] spoiler(input int unsigned j);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    for (int t = 0; t < 16 && plan_tbl[c][j]; t++) c = CHAR_W'($urandom_range(0, 255));
    return c;
  endfunction

  // small alphabet whose classes cover every query position
  task automatic plan_query(input int unsigned q);
    logic [MASK_W-1:0] mask;
    int unsigned       k;
    alphabet.delete();
    k = $urandom_range(2, 6);
    repeat (k) alphabet.push_back(CHAR_W'($urandom_range(0, 255)));
    for (int j = 0; j < q; j++) query_bytes[j] = alphabet[$urandom_range(0, k - 1)];
    foreach (alphabet[i]) begin
      mask = $urandom() & $urandom();
      for (int j = 0; j < q; j++) if (query_bytes[j] == alphabet[i]) mask[j] = 1'b1;
      queue_load(alphabet[i], mask, 1'(($urandom_range(0, 1))));
    end
  endtask

  // one line: query embedded, spread out, spoiled, or plain noise
  task automatic build_line(input int unsigned q);
    int unsigned kind;
    int unsigned lead;
    int unsigned tail;
    line_buf.delete();
    kind = $urandom_range(0, 9);
    lead = (kind == 3) ? 0 : $urandom_range(0, 6);
    tail = (kind == 4) ? 0 : $urandom_range(0, 6);
    if (kind <= 7) begin
      repeat (lead) line_buf.push_back(filler());
      for (int j = 0; j < q; j++) begin
        if (kind == 5 || kind == 6) repeat ($urandom_range(0, 2)) line_buf.push_back(filler());
        line_buf.push_back(query_bytes[j]);
      end
      repeat (tail) line_buf.push_back(filler());
      if (kind == 7) begin
        lead = lead + $urandom_range(0, q - 1);
        line_buf[lead] = spoiler(lead - (line_buf.size() - tail - q));
      end
    end else begin
      repeat ($urandom_range(1, (kind == 8) ? q : 12)) line_buf.push_back(filler());
    end
  endtask

  // send the buffered line; stray loads may land inside it
  task automatic flush_line(input logic close, input logic strays);
    foreach (line_buf[i]) begin
      if (strays && $urandom_range(0, 31) == 0)
        queue_load(CHAR_W'($urandom_range(0, 255)), $urandom(), 1'($urandom_range(0, 1)));
      queue_text(line_buf[i], (i == line_buf.size() - 1) ? close : 1'b0);
    end
    line_buf.delete();
  endtask

  // wait until every queued word is in and every report is out
  task automatic settle();
    while (words_to_send.size() != 0 || in_valid || reports_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned       q_raw;
    int unsigned       q_eff;
    int unsigned       phase_start;
    int unsigned       long_len;
    int unsigned       wait_cycles;
    logic [MODE_W-1:0] mode_sel;
    logic [CFG_W-1:0]  mode_word;
    foreach (plan_tbl[i]) plan_tbl[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: one position, leftmost substring
    queue_load(8'h00, '1, 1'b1);
    queue_load(8'hFF, 32'h0000_0001, 1'b0);
    queue_load(8'h80, 32'h8000_0000, 1'b0);
    queue_text(8'hFF, 1'b1);
    queue_text(8'h80, 1'b0);
    queue_text(8'h00, 1'b1);
    queue_text(8'h7F, 1'b1);
    settle();
    // zero query length behaves as one; prefix mode
    write_reg(CFG_QLEN, '0);
    write_reg(CFG_MODE, CFG_W'(MODE_PREFIX));
    @(posedge clk);
    queue_text(8'h00, 1'b1);
    queue_text(8'h80, 1'b0);
    queue_text(8'h00, 1'b1);
    settle();
    // suffix of two: a line shorter than the query, then a hit at the end
    write_reg(CFG_QLEN, CFG_W'(2));
    write_reg(CFG_MODE, CFG_W'(MODE_SUFFIX));
    @(posedge clk);
    queue_text(8'hFF, 1'b1);
    queue_text(8'h80, 1'b0);
    queue_text(8'h00, 1'b0);
    queue_text(8'h00, 1'b1);
    queue_text(8'h00, 1'b0);
    settle();
    // mode switch with that line still open
    write_reg(CFG_MODE, CFG_W'(MODE_SUBSEQ));
    @(posedge clk);
    queue_text(8'h00, 1'b1);

    // random phases, each under its own query length and mode
    words_queued = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       q_raw = 32;
        1:       q_raw = 1;
        2:       q_raw = 0;
        3:       q_raw = 63;
        4:       q_raw = 33;
        default: q_raw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 32);
      endcase
      q_eff = (q_raw == 0) ? 1 : ((q_raw > QUERY_CAP) ? QUERY_CAP : q_raw);
      mode_sel = (ph < 8) ? MODE_W'(ph % 4) : MODE_W'($urandom_range(0, 3));
      mode_word = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom()) : '0;
      mode_word[MODE_W-1:0] = mode_sel;
      write_reg(CFG_QLEN, CFG_W'(q_raw));
      write_reg(CFG_MODE, mode_word);
      @(posedge clk);
      plan_query(q_eff);

      // in three phases, one line at or beyond the length limit, query at the tail
      if (ph == 5 || ph == 9 || ph == 13) begin
        case (ph)
          5:       long_len = MAX_LINE;
          9:       long_len = MAX_LINE + 1;
          default: long_len = MAX_LINE + $urandom_range(2, 100);
        endcase
        repeat (long_len - q_eff) line_buf.push_back(filler());
        for (int j = 0; j < q_eff; j++) line_buf.push_back(query_bytes[j]);
        flush_line(1'b1, 1'b0);
      end

      phase_start = words_queued;
      while (words_queued - phase_start < RANDOM_WORDS / PHASES) begin
        build_line(q_eff);
        flush_line(1'b1, 1'b1);
      end
      // leave a line open across the next register change
      if (ph % 4 == 2) begin
        build_line(q_eff);
        flush_line(1'b0, 1'b1);
      end
    end
    queue_text(filler(), 1'b1);

    // drain, then a short quiet spell for stray reports
    wait_cycles = 0;
    while ((words_to_send.size() != 0 || in_valid || reports_due.size() != 0) &&
           wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (reports_due.size() != 0) begin
      $display("%0d line reports never arrived", reports_due.size());
      mismatches += reports_due.size();
    end

    $display("covered %0d words (%0d class loads), %0d register writes, %0d drain pauses",
             words_taken, loads_taken, cfg_writes, drain_pauses);
    $display("line reports checked %0d: %0d matches, %0d misses, %0d overlong lines",
             reports_checked, n_match, n_none, n_long);
    if (mismatches == 0) begin
      $display("class_pattern_line_matcher test passed");
    end else begin
      $display("class_pattern_line_matcher test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("class_pattern_line_matcher test failed");
    $finish;
  end

endmodule
